[src/spcp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the segment pair closest points block.
// Used by every module under src; depends on nothing else.
package spcp_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int WIDE_W  = 64;
  localparam int FRAC_W  = 16;
  localparam int PARAM_W = 16;

  localparam int LAT_DOT  = 2;
  localparam int LAT_MUL  = 3;
  localparam int LAT_DIV  = PARAM_W + 1;
  localparam int LAT_LERP = 2;
  localparam int LAT_TOTAL = 1 + LAT_DOT + LAT_MUL + 1 + LAT_DIV + 1 + LAT_LERP;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic        [PARAM_W:0]   param_t;

  typedef coord_t vec_coord_t [3];
  typedef diff_t  vec_diff_t  [3];

  localparam wide_t  WIDE_MAX  = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam wide_t  WIDE_MIN  = {1'b1, {(WIDE_W-1){1'b0}}};
  localparam param_t PARAM_ONE = {1'b1, {PARAM_W{1'b0}}};

  typedef struct packed {
    logic s_one;
    logic t_one;
  } pair_t;

  typedef struct packed {
    logic  den_zero;
    pair_t pair;
  } ctl_t;

  typedef struct packed {
    logic zero;
    logic one;
  } div_flag_t;

  function automatic diff_t sub_pt(coord_t a, coord_t b);
    sub_pt = diff_t'(a) - diff_t'(b);
  endfunction

  function automatic wide_t sat_add64(wide_t a, wide_t b);
    logic signed [WIDE_W:0] s;
    s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
    if (s[WIDE_W] != s[WIDE_W-1]) begin
      sat_add64 = s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
    end else begin
      sat_add64 = s[WIDE_W-1:0];
    end
  endfunction

  function automatic wide_t sat_sub64(wide_t a, wide_t b);
    logic signed [WIDE_W:0] s;
    s = {a[WIDE_W-1], a} - {b[WIDE_W-1], b};
    if (s[WIDE_W] != s[WIDE_W-1]) begin
      sat_sub64 = s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
    end else begin
      sat_sub64 = s[WIDE_W-1:0];
    end
  endfunction

endpackage

[src/spcp_dot3.sv]
`timescale 1ns / 1ps
// Three-term dot product of coordinate differences, saturated to 64 bits, two register stages.
// Depends on spcp_pkg.
module spcp_dot3 (
  input  logic               clk,
  input  spcp_pkg::vec_diff_t u,
  input  spcp_pkg::vec_diff_t v,
  output spcp_pkg::wide_t     dot
);
  import spcp_pkg::*;

  wide_t prod_r [3];
  wide_t prod_nxt [3];
  wide_t dot_r;
  wide_t dot_nxt;

  always_comb begin
    logic signed [2*DIFF_W-1:0] p;
    for (int k = 0; k < 3; k++) begin
      p = (2*DIFF_W)'(u[k]) * (2*DIFF_W)'(v[k]);
      if (p[2*DIFF_W-1:WIDE_W-1] == '0 || p[2*DIFF_W-1:WIDE_W-1] == '1) begin
        prod_nxt[k] = p[WIDE_W-1:0];
      end else begin
        prod_nxt[k] = p[2*DIFF_W-1] ? WIDE_MIN : WIDE_MAX;
      end
    end
  end

  assign dot_nxt = sat_add64(sat_add64(prod_r[0], prod_r[1]), prod_r[2]);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    dot_r  <= dot_nxt;
  end

  assign dot = dot_r;

endmodule

[src/spcp_mulsh.sv]
`timescale 1ns / 1ps
// 64 by 64 signed product shifted right by the fraction width with floor and saturation.
// Built from four 32 by 32 partial products over three register stages; depends on spcp_pkg.
module spcp_mulsh (
  input  logic            clk,
  input  spcp_pkg::wide_t a,
  input  spcp_pkg::wide_t b,
  output spcp_pkg::wide_t y
);
  import spcp_pkg::*;

  localparam int HALF = WIDE_W / 2;
  localparam int FULL = 2 * WIDE_W;
  localparam int QW   = FULL - FRAC_W;

  logic [WIDE_W-1:0] mag_a, mag_b;
  logic [WIDE_W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic              neg1_r, neg2_r;
  logic [FULL-1:0]   full_r, full_nxt;
  wide_t             y_r, y_nxt;

  assign mag_a = a[WIDE_W-1] ? WIDE_W'(0) - a : a;
  assign mag_b = b[WIDE_W-1] ? WIDE_W'(0) - b : b;

  always_ff @(posedge clk) begin
    p00_r  <= WIDE_W'(mag_a[HALF-1:0])      * WIDE_W'(mag_b[HALF-1:0]);
    p01_r  <= WIDE_W'(mag_a[HALF-1:0])      * WIDE_W'(mag_b[WIDE_W-1:HALF]);
    p10_r  <= WIDE_W'(mag_a[WIDE_W-1:HALF]) * WIDE_W'(mag_b[HALF-1:0]);
    p11_r  <= WIDE_W'(mag_a[WIDE_W-1:HALF]) * WIDE_W'(mag_b[WIDE_W-1:HALF]);
    neg1_r <= a[WIDE_W-1] ^ b[WIDE_W-1];
  end

  assign full_nxt = {{WIDE_W{1'b0}}, p00_r}
                  + {{HALF{1'b0}}, p01_r, {HALF{1'b0}}}
                  + {{HALF{1'b0}}, p10_r, {HALF{1'b0}}}
                  + {p11_r, {WIDE_W{1'b0}}};

  always_ff @(posedge clk) begin
    full_r <= full_nxt;
    neg2_r <= neg1_r;
  end

  always_comb begin
    logic [QW-1:0] q;
    logic [QW:0]   qq;
    q  = full_r[FULL-1:FRAC_W];
    qq = {1'b0, q} + (QW+1)'(|full_r[FRAC_W-1:0]);
    if (!neg2_r) begin
      y_nxt = (|q[QW-1:WIDE_W-1]) ? WIDE_MAX : {1'b0, q[WIDE_W-2:0]};
    end else begin
      y_nxt = (|qq[QW:WIDE_W-1]) ? WIDE_MIN : WIDE_W'(0) - qq[WIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
  end

  assign y = y_r;

endmodule

[src/spcp_div.sv]
`timescale 1ns / 1ps
// Clamped ratio num/den in Q1.16 by a pipelined restoring divider, one quotient bit per stage.
// Depends on spcp_pkg.
module spcp_div (
  input  logic             clk,
  input  spcp_pkg::wide_t  num,
  input  spcp_pkg::wide_t  den,
  output spcp_pkg::param_t ratio
);
  import spcp_pkg::*;

  logic [WIDE_W-1:0]  rem_r  [PARAM_W+1];
  logic [WIDE_W-1:0]  ud_r   [PARAM_W+1];
  logic [PARAM_W-1:0] q_r    [PARAM_W+1];
  div_flag_t          flag_r [PARAM_W+1];
  logic [WIDE_W-1:0]  un, ud;
  div_flag_t          flag_nxt;

  assign un = num[WIDE_W-1] ? WIDE_W'(0) - num : num;
  assign ud = den[WIDE_W-1] ? WIDE_W'(0) - den : den;
  assign flag_nxt.zero = (num == '0) || (den == '0) || (num[WIDE_W-1] != den[WIDE_W-1]);
  assign flag_nxt.one  = un >= ud;

  always_ff @(posedge clk) begin
    rem_r[0]  <= un;
    ud_r[0]   <= ud;
    q_r[0]    <= '0;
    flag_r[0] <= flag_nxt;
  end

  for (genvar k = 0; k < PARAM_W; k++) begin : g_step
    logic [WIDE_W:0] rem2;
    logic            ge;
    assign rem2 = {rem_r[k], 1'b0};
    assign ge   = rem2 >= {1'b0, ud_r[k]};
    always_ff @(posedge clk) begin
      rem_r[k+1]  <= ge ? WIDE_W'(rem2 - {1'b0, ud_r[k]}) : rem2[WIDE_W-1:0];
      ud_r[k+1]   <= ud_r[k];
      q_r[k+1]    <= {q_r[k][PARAM_W-2:0], ge};
      flag_r[k+1] <= flag_r[k];
    end
  end

  assign ratio = flag_r[PARAM_W].zero ? '0 :
                 flag_r[PARAM_W].one  ? PARAM_ONE : {1'b0, q_r[PARAM_W]};

endmodule

[src/spcp_lerp.sv]
`timescale 1ns / 1ps
// Point on a segment: start plus floor of difference times parameter, per axis, two stages.
// Depends on spcp_pkg.
module spcp_lerp (
  input  logic                 clk,
  input  spcp_pkg::vec_coord_t start_pt,
  input  spcp_pkg::vec_diff_t  diff,
  input  spcp_pkg::param_t     param,
  output spcp_pkg::vec_coord_t pt
);
  import spcp_pkg::*;

  localparam int PROD_W = DIFF_W + PARAM_W + 2;
  localparam int SUM_W  = PROD_W - PARAM_W;

  logic signed [PROD_W-1:0] prod_r [3];
  coord_t                   start_r [3];
  coord_t                   pt_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod_r[k]  <= PROD_W'(diff[k]) * PROD_W'($signed({1'b0, param}));
      start_r[k] <= start_pt[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pt_r[k] <= COORD_W'(SUM_W'(start_r[k]) + $signed(prod_r[k][PROD_W-1:PARAM_W]));
    end
  end

  assign pt = pt_r;

endmodule

[src/segment_pair_closest_points.sv]
`timescale 1ns / 1ps
// Top level: closest points between two 3D segments, fully pipelined.
// Depends on spcp_pkg, spcp_dot3, spcp_mulsh, spcp_div and spcp_lerp.
//
//   Channel  | Ports                     | Transfer
//   ---------+---------------------------+------------------------------
//   input    | start, busy, in_*         | start high while busy is low
//   result   | out_valid, out_*          | out_valid high for one cycle
//
// One segment pair is taken in every cycle; busy never rises.
// Each result goes in order through the input registers, dot products, split
// 64-bit products, subtractors, divider, parameter register and lerp stages.
// The synchronous reset clears the valid bits only; the datapath holds no state.
// The receiver cannot stall, so the pipeline never holds or drops an item.
module segment_pair_closest_points (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  spcp_pkg::coord_t    in_a_start_x,
  input  spcp_pkg::coord_t    in_a_start_y,
  input  spcp_pkg::coord_t    in_a_start_z,
  input  spcp_pkg::coord_t    in_a_end_x,
  input  spcp_pkg::coord_t    in_a_end_y,
  input  spcp_pkg::coord_t    in_a_end_z,
  input  spcp_pkg::coord_t    in_b_start_x,
  input  spcp_pkg::coord_t    in_b_start_y,
  input  spcp_pkg::coord_t    in_b_start_z,
  input  spcp_pkg::coord_t    in_b_end_x,
  input  spcp_pkg::coord_t    in_b_end_y,
  input  spcp_pkg::coord_t    in_b_end_z,
  output logic                out_valid,
  output spcp_pkg::param_t    out_param_s,
  output spcp_pkg::param_t    out_param_t,
  output spcp_pkg::coord_t    out_near_a_x,
  output spcp_pkg::coord_t    out_near_a_y,
  output spcp_pkg::coord_t    out_near_a_z,
  output spcp_pkg::coord_t    out_near_b_x,
  output spcp_pkg::coord_t    out_near_b_y,
  output spcp_pkg::coord_t    out_near_b_z
);
  import spcp_pkg::*;

  localparam int SIDE_LEN = 1 + LAT_DOT + LAT_MUL + 1 + LAT_DIV + 1 - 1;
  localparam int FB_LEN   = LAT_MUL + 1;

  logic [LAT_TOTAL:1] vld_r;

  vec_coord_t p1, p2, p3, p4;
  vec_coord_t p1_r, p3_r;
  vec_diff_t  d21_r, d43_r, d31_r, d41_r, d32_r, d42_r;

  vec_coord_t side_p1_r  [SIDE_LEN];
  vec_coord_t side_p3_r  [SIDE_LEN];
  vec_diff_t  side_d21_r [SIDE_LEN];
  vec_diff_t  side_d43_r [SIDE_LEN];

  wide_t r21, r22, d4321, d3121, d4331, q13, q14, q23, q24;
  wide_t m_rr, m_dd, m_sr, m_dq, m_ds, m_qr;
  wide_t den_r, ns_r, nt_r;

  pair_t  pair_nxt;
  pair_t  fb_r  [FB_LEN];
  ctl_t   ctl_r [LAT_DIV];
  param_t div_s, div_t;
  param_t s_nxt, t_nxt;
  param_t s_r [LAT_LERP+1];
  param_t t_r [LAT_LERP+1];
  vec_coord_t near_a, near_b;

  assign busy = 1'b0;

  assign p1 = '{in_a_start_x, in_a_start_y, in_a_start_z};
  assign p2 = '{in_a_end_x,   in_a_end_y,   in_a_end_z};
  assign p3 = '{in_b_start_x, in_b_start_y, in_b_start_z};
  assign p4 = '{in_b_end_x,   in_b_end_y,   in_b_end_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT_TOTAL-1:1], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p1_r[k]  <= p1[k];
      p3_r[k]  <= p3[k];
      d21_r[k] <= sub_pt(p2[k], p1[k]);
      d43_r[k] <= sub_pt(p4[k], p3[k]);
      d31_r[k] <= sub_pt(p3[k], p1[k]);
      d41_r[k] <= sub_pt(p4[k], p1[k]);
      d32_r[k] <= sub_pt(p3[k], p2[k]);
      d42_r[k] <= sub_pt(p4[k], p2[k]);
    end
  end

  always_ff @(posedge clk) begin
    side_p1_r[0]  <= p1_r;
    side_p3_r[0]  <= p3_r;
    side_d21_r[0] <= d21_r;
    side_d43_r[0] <= d43_r;
    for (int i = 1; i < SIDE_LEN; i++) begin
      side_p1_r[i]  <= side_p1_r[i-1];
      side_p3_r[i]  <= side_p3_r[i-1];
      side_d21_r[i] <= side_d21_r[i-1];
      side_d43_r[i] <= side_d43_r[i-1];
    end
  end

  spcp_dot3 u_r21   (.clk(clk), .u(d21_r), .v(d21_r), .dot(r21));
  spcp_dot3 u_r22   (.clk(clk), .u(d43_r), .v(d43_r), .dot(r22));
  spcp_dot3 u_d4321 (.clk(clk), .u(d43_r), .v(d21_r), .dot(d4321));
  spcp_dot3 u_d3121 (.clk(clk), .u(d31_r), .v(d21_r), .dot(d3121));
  spcp_dot3 u_d4331 (.clk(clk), .u(d43_r), .v(d31_r), .dot(d4331));
  spcp_dot3 u_q13   (.clk(clk), .u(d31_r), .v(d31_r), .dot(q13));
  spcp_dot3 u_q14   (.clk(clk), .u(d41_r), .v(d41_r), .dot(q14));
  spcp_dot3 u_q23   (.clk(clk), .u(d32_r), .v(d32_r), .dot(q23));
  spcp_dot3 u_q24   (.clk(clk), .u(d42_r), .v(d42_r), .dot(q24));

  always_comb begin
    wide_t best;
    best     = q13;
    pair_nxt = '{s_one: 1'b0, t_one: 1'b0};
    if (q14 < best) begin
      best     = q14;
      pair_nxt = '{s_one: 1'b0, t_one: 1'b1};
    end
    if (q23 < best) begin
      best     = q23;
      pair_nxt = '{s_one: 1'b1, t_one: 1'b0};
    end
    if (q24 < best) begin
      pair_nxt = '{s_one: 1'b1, t_one: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    fb_r[0] <= pair_nxt;
    for (int i = 1; i < FB_LEN; i++) begin
      fb_r[i] <= fb_r[i-1];
    end
  end

  spcp_mulsh u_m_rr (.clk(clk), .a(r21),   .b(r22),   .y(m_rr));
  spcp_mulsh u_m_dd (.clk(clk), .a(d4321), .b(d4321), .y(m_dd));
  spcp_mulsh u_m_sr (.clk(clk), .a(d3121), .b(r22),   .y(m_sr));
  spcp_mulsh u_m_dq (.clk(clk), .a(d4321), .b(d4331), .y(m_dq));
  spcp_mulsh u_m_ds (.clk(clk), .a(d4321), .b(d3121), .y(m_ds));
  spcp_mulsh u_m_qr (.clk(clk), .a(d4331), .b(r21),   .y(m_qr));

  always_ff @(posedge clk) begin
    den_r <= sat_sub64(m_rr, m_dd);
    ns_r  <= sat_sub64(m_sr, m_dq);
    nt_r  <= sat_sub64(m_ds, m_qr);
  end

  always_ff @(posedge clk) begin
    ctl_r[0] <= '{den_zero: (den_r == '0), pair: fb_r[FB_LEN-1]};
    for (int i = 1; i < LAT_DIV; i++) begin
      ctl_r[i] <= ctl_r[i-1];
    end
  end

  spcp_div u_div_s (.clk(clk), .num(ns_r), .den(den_r), .ratio(div_s));
  spcp_div u_div_t (.clk(clk), .num(nt_r), .den(den_r), .ratio(div_t));

  always_comb begin
    if (ctl_r[LAT_DIV-1].den_zero) begin
      s_nxt = ctl_r[LAT_DIV-1].pair.s_one ? PARAM_ONE : '0;
      t_nxt = ctl_r[LAT_DIV-1].pair.t_one ? PARAM_ONE : '0;
    end else begin
      s_nxt = div_s;
      t_nxt = div_t;
    end
  end

  always_ff @(posedge clk) begin
    s_r[0] <= s_nxt;
    t_r[0] <= t_nxt;
    for (int i = 1; i <= LAT_LERP; i++) begin
      s_r[i] <= s_r[i-1];
      t_r[i] <= t_r[i-1];
    end
  end

  spcp_lerp u_lerp_a (
    .clk(clk), .start_pt(side_p1_r[SIDE_LEN-1]), .diff(side_d21_r[SIDE_LEN-1]),
    .param(s_r[0]), .pt(near_a)
  );
  spcp_lerp u_lerp_b (
    .clk(clk), .start_pt(side_p3_r[SIDE_LEN-1]), .diff(side_d43_r[SIDE_LEN-1]),
    .param(t_r[0]), .pt(near_b)
  );

  assign out_valid    = vld_r[LAT_TOTAL];
  assign out_param_s  = s_r[LAT_LERP];
  assign out_param_t  = t_r[LAT_LERP];
  assign out_near_a_x = near_a[0];
  assign out_near_a_y = near_a[1];
  assign out_near_a_z = near_a[2];
  assign out_near_b_x = near_b[0];
  assign out_near_b_y = near_b[1];
  assign out_near_b_z = near_b[2];

`ifndef SYNTHESIS
  // A result only ever follows a transfer made the full latency earlier.
  a_valid_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT_TOTAL))
    else $error("result without a matching input transfer");

  a_s_zero_gives_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_param_s == '0 |-> out_near_a_x == $past(in_a_start_x, LAT_TOTAL))
    else $error("zero s does not give the start of segment A");

  a_s_one_gives_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_param_s == PARAM_ONE |-> out_near_a_y == $past(in_a_end_y, LAT_TOTAL))
    else $error("unit s does not give the end of segment A");

  a_t_zero_gives_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_param_t == '0 |-> out_near_b_z == $past(in_b_start_z, LAT_TOTAL))
    else $error("zero t does not give the start of segment B");
`endif

endmodule
